### hw/rtl/cel_pkg.sv
// Shared types, codes and constants of the compacting entry list.
`default_nettype none

package cel_pkg;

	// Field widths fixed by the request and result formats.
	localparam int ACTION_W    = 3;
	localparam int POSITION_W  = 6;
	localparam int VALUE_W     = 32;
	localparam int DROP_W      = 7;
	localparam int STATUS_W    = 2;
	localparam int COUNT_OUT_W = 7;

	// Default number of entries the list can hold.
	localparam int DEPTH_DEFAULT = 64;

	// Request codes; the remaining codes are ignored.
	typedef enum logic [ACTION_W-1:0] {
		ACT_APPEND       = 3'd0,
		ACT_GET          = 3'd1,
		ACT_REMOVE_AT    = 3'd2,
		ACT_REMOVE_VALUE = 3'd3,
		ACT_SHRINK       = 3'd4
	} action_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		STS_OK        = 2'd0,
		STS_FULL      = 2'd1,
		STS_RANGE     = 2'd2,
		STS_NOT_FOUND = 2'd3
	} status_t;

	// Controller states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_GET_WAIT,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_MOVE_RD,
		S_MOVE_WR,
		S_FINISH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    capture;
		logic    do_append;
		logic    do_shrink;
		logic    dec_count;
		logic    rd_pos;
		logic    rd_idx;
		logic    rd_next;
		logic    wr_move;
		logic    idx_load_pos;
		logic    idx_load_zero;
		logic    idx_inc;
		logic    set_res;
		status_t res_status;
		logic    res_take_rd;
		logic    load_out;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		action_t action;
		logic    pos_ok;
		logic    full;
		logic    move_done;
		logic    scan_end;
		logic    match;
		logic    out_free;
	} dp_status_t;

endpackage

`default_nettype wire

### hw/rtl/cel_if.sv
// Request and response channel interfaces of the compacting entry list.
`default_nettype none

interface cel_req_if;
	logic                          valid;
	logic                          ready;
	logic [cel_pkg::ACTION_W-1:0]   action;
	logic [cel_pkg::POSITION_W-1:0] position;
	logic [cel_pkg::VALUE_W-1:0]    entry_value;
	logic [cel_pkg::DROP_W-1:0]     drop_amount;

	modport source (
		output valid, action, position, entry_value, drop_amount,
		input  ready
	);
	modport sink (
		input  valid, action, position, entry_value, drop_amount,
		output ready
	);
endinterface

interface cel_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [cel_pkg::VALUE_W-1:0]     read_value;
	logic [cel_pkg::STATUS_W-1:0]    status;
	logic [cel_pkg::COUNT_OUT_W-1:0] entry_count;

	modport source (
		output valid, read_value, status, entry_count,
		input  ready
	);
	modport sink (
		input  valid, read_value, status, entry_count,
		output ready
	);
endinterface

`default_nettype wire

### hw/rtl/cel_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module cel_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

### hw/rtl/cel_datapath.sv
// Datapath of the compacting entry list: request latch, count, index, RAM and result register.
`default_nettype none

module cel_datapath #(
	parameter int DEPTH = cel_pkg::DEPTH_DEFAULT
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic [cel_pkg::ACTION_W-1:0]     req_action,
	input  wire logic [cel_pkg::POSITION_W-1:0]   req_position,
	input  wire logic [cel_pkg::VALUE_W-1:0]      req_entry_value,
	input  wire logic [cel_pkg::DROP_W-1:0]       req_drop_amount,
	input  wire cel_pkg::dp_cmd_t                 cmd,
	output cel_pkg::dp_status_t                   st,
	input  wire logic                            rsp_ready,
	output logic                                 rsp_valid,
	output logic      [cel_pkg::VALUE_W-1:0]      read_value,
	output logic      [cel_pkg::STATUS_W-1:0]     status,
	output logic      [cel_pkg::COUNT_OUT_W-1:0]  entry_count
);

	import cel_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int KW = (CW > DROP_W) ? CW : DROP_W;

	logic [ACTION_W-1:0]   action_q;
	logic [POSITION_W-1:0] pos_q;
	logic [VALUE_W-1:0]    value_q;
	logic [DROP_W-1:0]     drop_q;

	logic [CW-1:0]         count_q;
	logic [CW-1:0]         count_d;
	logic [CW-1:0]         idx_q;
	logic [CW:0]           idx_next;

	logic                  ram_wr_en;
	logic [AW-1:0]         ram_wr_addr;
	logic [VALUE_W-1:0]    ram_wr_data;
	logic                  ram_rd_en;
	logic [AW-1:0]         ram_rd_addr;
	logic [VALUE_W-1:0]    ram_rd_data;

	status_t               res_status_q;
	logic [VALUE_W-1:0]    res_value_q;
	status_t               res_status_now;
	logic [VALUE_W-1:0]    res_value_now;
	logic                  out_free;

	// Request latch, loaded on the input transfer.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q <= req_action;
			pos_q    <= req_position;
			value_q  <= req_entry_value;
			drop_q   <= req_drop_amount;
		end
	end

	assign idx_next = {1'b0, idx_q} + (CW + 1)'(1);

	// Next entry count for append, removal and shrink.
	always_comb begin
		count_d = count_q;
		if (cmd.do_append) begin
			count_d = count_q + CW'(1);
		end else if (cmd.dec_count) begin
			count_d = count_q - CW'(1);
		end else if (cmd.do_shrink) begin
			if (KW'(drop_q) <= KW'(count_q)) begin
				count_d = count_q - CW'(drop_q);
			end else begin
				count_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	// Walk index for the search and for moving entries down.
	always_ff @(posedge clk) begin
		if (cmd.idx_load_pos) begin
			idx_q <= CW'(pos_q);
		end else if (cmd.idx_load_zero) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_next[CW-1:0];
		end
	end

	// RAM port selection.
	always_comb begin
		ram_wr_en   = cmd.do_append | cmd.wr_move;
		ram_wr_addr = cmd.wr_move ? idx_q[AW-1:0] : count_q[AW-1:0];
		ram_wr_data = cmd.wr_move ? ram_rd_data : value_q;
		ram_rd_en   = cmd.rd_pos | cmd.rd_idx | cmd.rd_next;
		if (cmd.rd_pos) begin
			ram_rd_addr = AW'(pos_q);
		end else if (cmd.rd_next) begin
			ram_rd_addr = idx_next[AW-1:0];
		end else begin
			ram_rd_addr = idx_q[AW-1:0];
		end
	end

	cel_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// Result held while the output register is still occupied.
	assign res_status_now = cmd.set_res ? cmd.res_status : res_status_q;
	assign res_value_now  = cmd.set_res ? (cmd.res_take_rd ? ram_rd_data : '0) : res_value_q;

	always_ff @(posedge clk) begin
		if (cmd.set_res) begin
			res_status_q <= res_status_now;
			res_value_q  <= res_value_now;
		end
	end

	// Output register; it frees as soon as its transfer completes.
	assign out_free = !rsp_valid || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (cmd.load_out) begin
			rsp_valid <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			read_value  <= res_value_now;
			status      <= res_status_now;
			entry_count <= COUNT_OUT_W'(count_d);
		end
	end

	// Status toward the controller.
	always_comb begin
		st.action    = action_t'(action_q);
		st.pos_ok    = KW'(pos_q) < KW'(count_q);
		st.full      = count_q == CW'(DEPTH);
		st.move_done = idx_next >= {1'b0, count_q};
		st.scan_end  = idx_q >= count_q;
		st.match     = ram_rd_data == value_q;
		st.out_free  = out_free;
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count beyond capacity");

	a_append_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_append |-> count_q < CW'(DEPTH))
		else $error("append written into a full list");

	a_move_inside: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_move |-> idx_next < {1'b0, count_q})
		else $error("entry move outside the held entries");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> out_free)
		else $error("result loaded over an unsent result");

	a_count_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> $past(cmd.do_append || cmd.dec_count || cmd.do_shrink))
		else $error("entry count changed without a command");

endmodule

`default_nettype wire

### hw/rtl/cel_controller.sv
// Controller state machine of the compacting entry list.
`default_nettype none

module cel_controller (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire cel_pkg::dp_status_t st,
	output cel_pkg::dp_cmd_t         cmd
);

	import cel_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (st.action)
					ACT_APPEND: begin
						cmd.set_res = 1'b1;
						if (st.full) begin
							cmd.res_status = STS_FULL;
						end else begin
							cmd.do_append = 1'b1;
						end
					end
					ACT_GET: begin
						if (st.pos_ok) begin
							cmd.rd_pos = 1'b1;
							state_d    = S_GET_WAIT;
						end else begin
							cmd.set_res    = 1'b1;
							cmd.res_status = STS_RANGE;
						end
					end
					ACT_REMOVE_AT: begin
						if (st.pos_ok) begin
							cmd.idx_load_pos = 1'b1;
							state_d          = S_MOVE_RD;
						end else begin
							cmd.set_res    = 1'b1;
							cmd.res_status = STS_RANGE;
						end
					end
					ACT_REMOVE_VALUE: begin
						cmd.idx_load_zero = 1'b1;
						state_d           = S_SCAN_RD;
					end
					ACT_SHRINK: begin
						cmd.do_shrink = 1'b1;
						cmd.set_res   = 1'b1;
					end
					default: begin
						// Unused codes complete with nothing changed.
						cmd.set_res = 1'b1;
					end
				endcase
			end
			S_GET_WAIT: begin
				cmd.set_res     = 1'b1;
				cmd.res_take_rd = 1'b1;
			end
			S_SCAN_RD: begin
				if (st.scan_end) begin
					cmd.set_res    = 1'b1;
					cmd.res_status = STS_NOT_FOUND;
				end else begin
					cmd.rd_idx = 1'b1;
					state_d    = S_SCAN_CMP;
				end
			end
			S_SCAN_CMP: begin
				if (st.match) begin
					state_d = S_MOVE_RD;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = S_SCAN_RD;
				end
			end
			S_MOVE_RD: begin
				if (st.move_done) begin
					cmd.dec_count = 1'b1;
					cmd.set_res   = 1'b1;
				end else begin
					cmd.rd_next = 1'b1;
					state_d     = S_MOVE_WR;
				end
			end
			S_MOVE_WR: begin
				cmd.wr_move = 1'b1;
				cmd.idx_inc = 1'b1;
				state_d     = S_MOVE_RD;
			end
			S_FINISH: begin
				if (st.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// A finished request goes straight out when the output register is free.
		if (cmd.set_res) begin
			if (st.out_free) begin
				cmd.load_out = 1'b1;
				state_d      = S_IDLE;
			end else begin
				state_d = S_FINISH;
			end
		end
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state_q == S_DECODE)
		else $error("accepted request not decoded");

	a_move_pairs: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MOVE_WR |-> $past(state_q) == S_MOVE_RD)
		else $error("entry move without a preceding read");

	a_get_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_GET_WAIT |-> $past(cmd.rd_pos))
		else $error("get result without a read");

endmodule

`default_nettype wire

### hw/rtl/compacting_entry_list_core.sv
// Top level of the compacting entry list: controller, datapath and channel wiring.
`default_nettype none

// An ordered list of up to DEPTH 32-bit entries, kept packed from position 0 in one
// RAM with a registered read port. Each request transfer (append, get, remove at index,
// remove first matching value, shrink) yields exactly one response transfer carrying the
// value read, a status and the new entry count. One request is worked on at a time; the
// next request is taken once the previous result has entered the output register, which
// may still be waiting for its own transfer. Removal moves the later entries down one at
// a time through the single RAM port pair, each move a read and then a write; remove-value
// first searches from position 0, reading and comparing one entry at a time.
module compacting_entry_list_core #(
	parameter int DEPTH = cel_pkg::DEPTH_DEFAULT
) (
	input wire logic  clk,
	input wire logic  arst_n,
	cel_req_if.sink   req,
	cel_rsp_if.source rsp
);

	import cel_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t st;

	cel_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.st       (st),
		.cmd      (cmd)
	);

	cel_datapath #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_action      (req.action),
		.req_position    (req.position),
		.req_entry_value (req.entry_value),
		.req_drop_amount (req.drop_amount),
		.cmd             (cmd),
		.st              (st),
		.rsp_ready       (rsp.ready),
		.rsp_valid       (rsp.valid),
		.read_value      (rsp.read_value),
		.status          (rsp.status),
		.entry_count     (rsp.entry_count)
	);

endmodule

`default_nettype wire

### sim/tb.sv
// Self-checking testbench for the compacting entry list core: directed and random requests.
`timescale 1ns / 1ps

module tb;
	import cel_pkg::*;

	localparam int DEPTH          = DEPTH_DEFAULT;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 2 * DEPTH + 16;
	localparam int RANDOM_ITEMS   = 840;

	// Request codes that the block ignores.
	localparam logic [ACTION_W-1:0] ACT_UNUSED_FIRST = 3'd5;
	localparam logic [ACTION_W-1:0] ACT_UNUSED_LAST  = 3'd7;

	localparam logic [VALUE_W-1:0] VALUE_ALL_ONES = '1;
	localparam logic [DROP_W-1:0]  DROP_ALL_ONES  = '1;

	typedef struct {
		logic [VALUE_W-1:0]     read_value;
		status_t                status;
		logic [COUNT_OUT_W-1:0] entry_count;
	} list_result_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	cel_req_if req_ch ();
	cel_rsp_if rsp_ch ();

	compacting_entry_list_core #(
		.DEPTH(DEPTH)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// Mirror of the list contents, updated at each accepted request transfer.
	logic [VALUE_W-1:0] golden_entries [DEPTH];
	int unsigned        golden_count = 0;
	list_result_t       pending_results [$];

	int error_count     = 0;
	int requests_sent   = 0;
	int results_checked = 0;
	int idle_cycles     = 0;
	int stall_left      = 0;
	int req_gap_pct     = 0;
	int rsp_stall_pct   = 0;
	int action_hits [8] = '{default: 0};
	int status_hits [4] = '{default: 0};

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Applies one request to the mirrored list and returns the result it must produce.
	function automatic list_result_t apply_list_request(
		input logic [ACTION_W-1:0]   act,
		input logic [POSITION_W-1:0] pos,
		input logic [VALUE_W-1:0]    val,
		input logic [DROP_W-1:0]     drop
	);
		list_result_t res;
		int hit;
		res.read_value = '0;
		res.status     = STS_OK;
		hit            = -1;
		case (act)
			ACT_APPEND: begin
				if (golden_count >= DEPTH) begin
					res.status = STS_FULL;
				end else begin
					golden_entries[golden_count] = val;
					golden_count++;
				end
			end
			ACT_GET: begin
				if (pos < golden_count)
					res.read_value = golden_entries[pos];
				else
					res.status = STS_RANGE;
			end
			ACT_REMOVE_AT: begin
				if (pos < golden_count)
					hit = pos;
				else
					res.status = STS_RANGE;
			end
			ACT_REMOVE_VALUE: begin
				for (int i = 0; i < golden_count; i++)
					if (hit < 0 && golden_entries[i] == val)
						hit = i;
				if (hit < 0)
					res.status = STS_NOT_FOUND;
			end
			ACT_SHRINK: begin
				golden_count = (drop <= golden_count) ? golden_count - drop : 0;
			end
			default: begin
			end
		endcase
		// A removal closes the hole by moving every later entry down one place.
		if (hit >= 0) begin
			for (int i = hit; i + 1 < golden_count; i++)
				golden_entries[i] = golden_entries[i + 1];
			golden_count--;
		end
		res.entry_count = COUNT_OUT_W'(golden_count);
		return res;
	endfunction

	// Idle length: zero unless the chance hits, then mostly short and now and then long.
	function automatic int pick_gap(input int pct);
		int r;
		if ($urandom_range(99) >= pct)
			return 0;
		r = $urandom_range(99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [ACTION_W-1:0] ACT_WIDTH_CAST(input int code);
		return ACTION_W'(code);
	endfunction

	// Drives one request and returns after its transfer, with the expected result queued.
	task automatic send_request(
		input logic [ACTION_W-1:0]   act,
		input logic [POSITION_W-1:0] pos,
		input logic [VALUE_W-1:0]    val,
		input logic [DROP_W-1:0]     drop
	);
		int gap;
		gap = pick_gap(req_gap_pct);
		if (gap > 0) begin
			@(negedge clk);
			req_ch.valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_ch.valid       = 1'b1;
		req_ch.action      = act;
		req_ch.position    = pos;
		req_ch.entry_value = val;
		req_ch.drop_amount = drop;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		pending_results.push_back(apply_list_request(act, pos, val, drop));
		requests_sent++;
		action_hits[act]++;
	endtask

	// Response ready: random stalls whose density follows rsp_stall_pct.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			rsp_ch.ready = 1'b0;
			stall_left--;
		end else begin
			stall_left   = pick_gap(rsp_stall_pct);
			rsp_ch.ready = (stall_left == 0);
			if (stall_left > 0)
				stall_left--;
		end
	end

	// Each response transfer is compared with the oldest expected result.
	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected response: read_value %h status %0d count %0d",
					$time, rsp_ch.read_value, rsp_ch.status, rsp_ch.entry_count);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				status_hits[want.status]++;
				if (rsp_ch.read_value !== want.read_value) begin
					$display("%0t: read_value expected %h actual %h",
						$time, want.read_value, rsp_ch.read_value);
					error_count++;
				end
				if (rsp_ch.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d",
						$time, want.status, rsp_ch.status);
					error_count++;
				end
				if (rsp_ch.entry_count !== want.entry_count) begin
					$display("%0t: entry_count expected %0d actual %0d",
						$time, want.entry_count, rsp_ch.entry_count);
					error_count++;
				end
			end
		end
	end

	// Watchdog: too long without any transfer on either channel ends the run.
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transfer for %0d cycles, run abandoned", $time, WATCHDOG_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Get, remove and shrink requests on a list that was never filled.
	task automatic test_empty_list();
		send_request(ACT_GET, '0, '0, '0);
		send_request(ACT_GET, '1, '0, '0);
		send_request(ACT_REMOVE_AT, '0, '0, '0);
		send_request(ACT_REMOVE_AT, '1, '0, '0);
		send_request(ACT_REMOVE_VALUE, '0, '0, '0);
		send_request(ACT_REMOVE_VALUE, '0, VALUE_ALL_ONES, '0);
		send_request(ACT_SHRINK, '0, '0, '0);
		send_request(ACT_SHRINK, '0, '0, DROP_ALL_ONES);
	endtask

	// Field extremes, matches and misses, ignored codes and shrink past empty.
	task automatic test_basic_ops();
		send_request(ACT_APPEND, '0, '0, '0);
		send_request(ACT_APPEND, '1, VALUE_ALL_ONES, DROP_ALL_ONES);
		send_request(ACT_APPEND, '0, 32'h8000_0001, '0);
		send_request(ACT_APPEND, '0, 32'h7FFF_FFFE, '0);
		send_request(ACT_GET, 6'd1, '0, '0);
		send_request(ACT_GET, 6'd3, '0, '0);
		send_request(ACT_GET, 6'd4, '0, '0);
		send_request(ACT_REMOVE_VALUE, '0, 32'h7FFF_FFFE, '0);
		send_request(ACT_REMOVE_VALUE, '0, 32'h1234_5678, '0);
		send_request(ACT_REMOVE_AT, '0, '0, '0);
		send_request(ACT_GET, '0, '0, '0);
		for (int code = ACT_UNUSED_FIRST; code <= ACT_UNUSED_LAST; code++)
			send_request(ACT_WIDTH_CAST(code), POSITION_W'($urandom), $urandom,
				DROP_W'($urandom));
		send_request(ACT_SHRINK, '0, '0, 7'd1);
		send_request(ACT_APPEND, '0, 32'h5A5A_A5A5, '0);
		send_request(ACT_SHRINK, '0, '0, 7'd64);
	endtask

	// A full list: refused appends, and the longest moves and searches.
	task automatic test_full_list();
		req_gap_pct   = 0;
		rsp_stall_pct = 0;
		while (golden_count < DEPTH)
			send_request(ACT_APPEND, POSITION_W'($urandom), $urandom, DROP_W'($urandom));
		req_gap_pct   = 30;
		rsp_stall_pct = 30;
		send_request(ACT_APPEND, '0, 32'hDEAD_0001, '0);
		send_request(ACT_APPEND, '1, VALUE_ALL_ONES, '0);
		send_request(ACT_GET, 6'(DEPTH - 1), '0, '0);
		send_request(ACT_REMOVE_AT, '0, '0, '0);
		send_request(ACT_APPEND, '0, 32'hC0DE_F00D, '0);
		send_request(ACT_REMOVE_VALUE, '0, golden_entries[DEPTH - 1], '0);
		send_request(ACT_APPEND, '0, golden_entries[0], '0);
		send_request(ACT_REMOVE_VALUE, '0, golden_entries[0], '0);
		send_request(ACT_REMOVE_AT, 6'(DEPTH - 1), '0, '0);
		send_request(ACT_SHRINK, '0, '0, 7'd64);
	endtask

	// Mixed traffic whose fill level and idling change every few dozen requests.
	task automatic test_random_traffic(input int n_items);
		int unsigned target;
		int r;
		logic [ACTION_W-1:0]   act;
		logic [POSITION_W-1:0] pos;
		logic [VALUE_W-1:0]    val;
		logic [DROP_W-1:0]     drop;
		target = 16;
		for (int n = 0; n < n_items; n++) begin
			if (n % 60 == 0) begin
				case ($urandom_range(3))
					0: begin req_gap_pct = 0;  rsp_stall_pct = 0;  end
					1: begin req_gap_pct = 20; rsp_stall_pct = 20; end
					2: begin req_gap_pct = 70; rsp_stall_pct = 10; end
					default: begin req_gap_pct = 10; rsp_stall_pct = 70; end
				endcase
				case ($urandom_range(3))
					0: target = 4;
					1: target = 20;
					2: target = 48;
					default: target = DEPTH;
				endcase
			end
			// Appends dominate below the target level so the list settles around it.
			r = $urandom_range(99);
			if (r < ((golden_count < target) ? 45 : 10))
				act = ACT_APPEND;
			else if (r < 62)
				act = ACT_GET;
			else if (r < 76)
				act = ACT_REMOVE_AT;
			else if (r < 90)
				act = ACT_REMOVE_VALUE;
			else if (r < 97)
				act = ACT_SHRINK;
			else
				act = ACT_WIDTH_CAST($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST));

			// A small value pool makes duplicates, so remove-value must take the first.
			val = ($urandom_range(99) < 40) ? VALUE_W'($urandom_range(7)) : $urandom;
			if (act == ACT_REMOVE_VALUE && golden_count > 0 && $urandom_range(99) < 65)
				val = golden_entries[$urandom_range(golden_count - 1)];

			if (golden_count > 0 && $urandom_range(99) < 80)
				pos = POSITION_W'($urandom_range(golden_count - 1));
			else
				pos = POSITION_W'($urandom);

			r = $urandom_range(99);
			if (r < 70)
				drop = DROP_W'($urandom_range(3));
			else if (r < 90)
				drop = DROP_W'($urandom_range(64));
			else
				drop = DROP_W'($urandom);

			send_request(act, pos, val, drop);
		end
	endtask

	initial begin
		req_ch.valid       = 1'b0;
		req_ch.action      = '0;
		req_ch.position    = '0;
		req_ch.entry_value = '0;
		req_ch.drop_amount = '0;
		for (int i = 0; i < DEPTH; i++)
			golden_entries[i] = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		req_gap_pct   = 30;
		rsp_stall_pct = 30;
		test_empty_list();
		test_basic_ops();
		test_full_list();
		test_random_traffic(RANDOM_ITEMS);

		// Withdraw the last request, let every response drain, then watch for strays.
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d requests: append %0d, get %0d, remove-at %0d, remove-value %0d,",
			requests_sent, action_hits[ACT_APPEND], action_hits[ACT_GET],
			action_hits[ACT_REMOVE_AT], action_hits[ACT_REMOVE_VALUE]);
		$display("shrink %0d, ignored %0d; %0d results (ok %0d, full %0d, range %0d, miss %0d), %0d errors",
			action_hits[ACT_SHRINK],
			action_hits[ACT_UNUSED_FIRST] + action_hits[ACT_UNUSED_FIRST + 1] +
				action_hits[ACT_UNUSED_LAST],
			results_checked, status_hits[STS_OK], status_hits[STS_FULL],
			status_hits[STS_RANGE], status_hits[STS_NOT_FOUND], error_count);
		if (error_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
